// ----- src/utf8_to_font_codepage_decoder_core_defines.svh -----
// Assertion macros for the UTF-8 to font code page decoder.
`ifndef UTF8_TO_FONT_CODEPAGE_DECODER_CORE_DEFINES_SVH
`define UTF8_TO_FONT_CODEPAGE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define U8FC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8fc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define U8FC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8fc assertion failed");

`endif

// ----- src/u8fc_pkg.sv -----
// Shared types and constants of the UTF-8 to font code page decoder.
`default_nettype none

package u8fc_pkg;

	localparam int unsigned ByteW = 8;

	// Lead bytes that select a mapping.
	localparam logic [ByteW-1:0] PFX_LATIN1 = 8'hC2;
	localparam logic [ByteW-1:0] PFX_LATIN2 = 8'hC3;
	localparam logic [ByteW-1:0] PFX_EURO   = 8'h82;
	localparam logic [ByteW-1:0] PFX_CYR0   = 8'hD0;
	localparam logic [ByteW-1:0] PFX_CYR1   = 8'hD1;
	localparam logic [ByteW-1:0] PFX_CYR2   = 8'hD2;

	// Input register contents handed from the front stage to the mapper.
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] cur;   // byte of this beat
		logic [ByteW-1:0] prev;  // remembered high byte before this beat
	} s1_t;

endpackage

`default_nettype wire

// ----- src/u8fc_front.sv -----
// Input register and one-byte lead memory of the decoder.
`default_nettype none

module u8fc_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  byte_valid,
	input  wire logic [7:0]            in_byte,
	output u8fc_pkg::s1_t              stage_s1
);
	import u8fc_pkg::*;

	logic             take;
	logic [ByteW-1:0] prev_high_q;
	logic             valid_s1;
	logic [ByteW-1:0] cur_s1;
	logic [ByteW-1:0] prev_s1;

	assign take = advance && byte_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			prev_high_q <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= byte_valid;
			end
			// ASCII clears the memory, anything else becomes the new lead
			if (take) begin
				prev_high_q <= in_byte[ByteW-1] ? in_byte : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_s1  <= in_byte;
			prev_s1 <= prev_high_q;
		end
	end

	assign stage_s1 = '{valid: valid_s1, cur: cur_s1, prev: prev_s1};

endmodule

`default_nettype wire

// ----- src/u8fc_map.sv -----
// Lead-byte selected mapping into the font code page.
`default_nettype none

module u8fc_map (
	input  wire u8fc_pkg::s1_t stage_s1,
	output logic [7:0]         code
);
	import u8fc_pkg::*;

	logic [ByteW-1:0] b;
	logic [ByteW-1:0] p;

	assign b = stage_s1.cur;
	assign p = stage_s1.prev;

	always_comb begin
		code = '0;
		if (!b[ByteW-1]) begin
			code = b;
		end else begin
			case (p)
				PFX_LATIN1: code = b;
				PFX_LATIN2: code = b | 8'hC0;
				PFX_EURO: begin
					code = (b == 8'hAC) ? 8'hEA : 8'h00;
				end
				PFX_CYR0: begin
					case (b) inside
						8'h81:          code = 8'h84;
						8'h84:          code = 8'hA0;
						8'h86:          code = 8'hA1;
						8'h87:          code = 8'h9F;
						[8'h90:8'hAF]:  code = b - 8'd17;
						[8'hB0:8'hBF]:  code = b - 8'd49;
						default:        code = 8'h00;
					endcase
				end
				PFX_CYR1: begin
					case (b) inside
						8'h91:          code = 8'h84;
						8'h94:          code = 8'hA0;
						8'h96:          code = 8'hA1;
						8'h97:          code = 8'h9F;
						[8'h80:8'h8F]:  code = b + 8'd15;
						default:        code = 8'h00;
					endcase
				end
				PFX_CYR2: begin
					code = (b == 8'h90 || b == 8'h91) ? 8'h82 : 8'h00;
				end
				default: code = 8'h00;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/utf8_to_font_codepage_decoder_core.sv -----
// Top level of the UTF-8 to font code page decoder.
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------
//  in       | byte_valid   | byte_ready   | in_byte    [7:0]
//  out      | glyph_valid  | glyph_ready  | glyph_code [7:0], 1..255
//
// One beat per cycle sustained while the output is not stalled; a byte is registered
// in the input register as it is taken and reaches glyph_code via the result register.
// The lead-byte memory is updated as the byte is taken, so back-to-back
// bytes see the right prefix without any feedback from the mapper.
// Reset clears the valid flags and the lead memory; payload flops are not reset.
// A byte that maps to code 0 is dropped in the input stage, so it never waits
// on a stalled output. Otherwise the input stage moves only when the result
// register is empty or being read.
`default_nettype none

module utf8_to_font_codepage_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] in_byte,
	output logic            glyph_valid,
	input  wire logic       glyph_ready,
	output logic [7:0]      glyph_code
);
	import u8fc_pkg::*;

`include "utf8_to_font_codepage_decoder_core_defines.svh"

	s1_t              stage_s1;
	logic [ByteW-1:0] code;
	logic             emit;      // stage 1 holds a beat with a nonzero result
	logic             out_free;  // result register can load this cycle
	logic             advance;   // stage 1 may take a new beat
	logic             glyph_valid_q;
	logic [ByteW-1:0] glyph_q;

	u8fc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.byte_valid (byte_valid),
		.in_byte    (in_byte),
		.stage_s1   (stage_s1)
	);

	u8fc_map u_map (
		.stage_s1 (stage_s1),
		.code     (code)
	);

	assign emit     = stage_s1.valid && (code != '0);
	assign out_free = !glyph_valid_q || glyph_ready;
	// stage 1 empties when its beat is dropped or handed to the result register
	assign advance  = !emit || out_free;

	assign byte_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_valid_q <= 1'b0;
		end else if (out_free) begin
			glyph_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			glyph_q <= code;
		end
	end

	assign glyph_valid = glyph_valid_q;
	assign glyph_code  = glyph_q;

	// zero codes must never leave the block
	`U8FC_ASSERT_IMP(a_no_zero_out, glyph_valid, glyph_code != 8'h00)
	// a mapped beat with room downstream shows up as a result next cycle
	`U8FC_ASSERT_NXT(a_emit_lands, emit && out_free, glyph_valid)
	// a mapped beat blocked by a full output stays in stage 1
	`U8FC_ASSERT_NXT(a_s1_holds, emit && !out_free, stage_s1.valid && $stable(stage_s1.cur))
	// input is refused only while a result is stuck downstream
	`U8FC_ASSERT_IMP(a_ready_why, !byte_ready, glyph_valid && !glyph_ready)

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the UTF-8 to font code page decoder: directed and random byte streams.
module tb_top;
	import u8fc_pkg::*;

	localparam int unsigned RandomBytes = 900;
	localparam int unsigned HoldCycles  = 300;  // receiver hold-off for the backpressure test
	localparam int unsigned DrainCycles = 10;   // block is two stages deep; spare edges after the last expected glyph
	localparam int unsigned MaxReports  = 10;

	// Three-byte euro sign E2 82 AC; the middle byte is the euro prefix.
	localparam logic [7:0] EURO_LEAD  = 8'hE2;
	localparam logic [7:0] EURO_TAIL  = 8'hAC;
	localparam logic [7:0] EURO_GLYPH = 8'hEA;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	logic [7:0] in_byte;
	logic       glyph_valid;
	logic       glyph_ready;
	logic [7:0] glyph_code;

	// Predictor state and the glyphs still owed by the block, oldest first.
	logic [7:0] lead_byte;
	logic [7:0] glyph_expect_q[$];

	int unsigned fail_count;
	int unsigned bytes_sent;

	// Idle controls for the sender and the receiver.
	bit tx_gaps_on;
	bit rx_stalls_on;
	bit hold_glyphs;

	utf8_to_font_codepage_decoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.in_byte    (in_byte),
		.glyph_valid(glyph_valid),
		.glyph_ready(glyph_ready),
		.glyph_code (glyph_code)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short idles, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 20);
	endfunction

	// Code page glyph for a high byte b following remembered high byte p; 0 means no glyph.
	function automatic logic [7:0] glyph_for_high(input logic [7:0] p, input logic [7:0] b);
		case (p)
			PFX_LATIN1: return b;
			PFX_LATIN2: return b | 8'hC0;
			PFX_EURO:   return (b == EURO_TAIL) ? EURO_GLYPH : 8'h00;
			PFX_CYR0: begin
				case (b)
					8'h81: return 8'h84;
					8'h84: return 8'hA0;
					8'h86: return 8'hA1;
					8'h87: return 8'h9F;
					default: begin
						if (b >= 8'h90 && b <= 8'hAF)
							return b - 8'd17;
						if (b >= 8'hB0 && b <= 8'hBF)
							return b - 8'd49;
						return 8'h00;
					end
				endcase
			end
			PFX_CYR1: begin
				case (b)
					8'h91: return 8'h84;
					8'h94: return 8'hA0;
					8'h96: return 8'hA1;
					8'h97: return 8'h9F;
					default: begin
						if (b >= 8'h80 && b <= 8'h8F)
							return b + 8'd15;
						return 8'h00;
					end
				endcase
			end
			PFX_CYR2: return (b == 8'h90 || b == 8'h91) ? 8'h82 : 8'h00;
			default:  return 8'h00;
		endcase
	endfunction

	// Advance the predictor by one accepted byte and queue its glyph, if any.
	task automatic predict_glyph(input logic [7:0] b);
		logic [7:0] code;
		if (b < 8'h80) begin
			code = b;
			lead_byte = 8'h00;
		end else begin
			code = glyph_for_high(lead_byte, b);
			lead_byte = b;
		end
		if (code != 8'h00)
			glyph_expect_q.push_back(code);
	endtask

	// Offer one byte from a falling edge; returns at a falling edge once it is taken
	// and any sender gap has passed. Valid stays up between back-to-back beats.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		byte_valid <= 1'b1;
		in_byte    <= b;
		do
			@(posedge clk);
		while (!byte_ready);
		predict_glyph(b);
		bytes_sent++;
		@(negedge clk);
		gap = tx_gaps_on ? idle_len() : 0;
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_pair(input logic [7:0] lead, input logic [7:0] cont);
		send_byte(lead);
		send_byte(cont);
	endtask

	// Receiver: random stalls, or one long hold-off when a test asks for it.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		glyph_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_glyphs) begin
				glyph_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				hold_glyphs = 1'b0;
			end else if (stall_left != 0) begin
				glyph_ready <= 1'b0;
				stall_left--;
			end else begin
				glyph_ready <= 1'b1;
				if (rx_stalls_on)
					stall_left = idle_len();
			end
		end
	end

	// Every glyph beat is matched against the oldest expected glyph.
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && glyph_valid && glyph_ready) begin
			if (glyph_expect_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MaxReports)
					$display("glyph_code: got 0x%02h, none expected", glyph_code);
			end else begin
				want = glyph_expect_q.pop_front();
				if (glyph_code !== want) begin
					fail_count++;
					if (fail_count <= MaxReports)
						$display("glyph_code: expected 0x%02h, got 0x%02h", want, glyph_code);
				end
			end
		end
	end

	// ASCII extremes; the zero byte clears the lead memory and gives no glyph.
	task automatic test_ascii_passthrough();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		send_byte(8'h00);
		send_byte(8'h41);
		send_byte(8'h7F);
	endtask

	task automatic test_latin_prefixes();
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		send_pair(PFX_LATIN1, 8'hA0);
		send_pair(PFX_LATIN2, 8'h80);
		send_pair(PFX_LATIN2, 8'hBF);
	endtask

	// Lead byte maps to nothing, the middle byte is remembered, the tail gives the glyph.
	task automatic test_euro_sign();
		send_byte(EURO_LEAD);
		send_pair(PFX_EURO, EURO_TAIL);
	endtask

	task automatic test_cyrillic();
		send_pair(PFX_CYR0, 8'h81);
		send_pair(PFX_CYR0, 8'hBF);
		send_pair(PFX_CYR1, 8'h80);
		send_pair(PFX_CYR1, 8'h97);
		send_pair(PFX_CYR2, 8'h90);
	endtask

	// Unmapped pair, a continuation byte judged against the invalid byte FF, and a repeated continuation.
	task automatic test_unmapped_and_continuation();
		send_pair(PFX_CYR2, 8'hFF);
		send_byte(8'h80);
		send_pair(PFX_LATIN1, 8'hA9);
		send_byte(8'hA9);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering ASCII
	// back to back, so the block fills and drops byte_ready.
	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_glyphs = 1'b1;
		for (int i = 0; i < 40; i++)
			send_byte(8'h41 + 8'(i % 26));
	endtask

	// Mostly ASCII and well-formed two and three byte sequences with random content, some noise.
	task automatic test_random_text();
		int unsigned kind;
		int unsigned stop_at;
		stop_at = bytes_sent + RandomBytes;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		while (bytes_sent < stop_at) begin
			// switch idling on and off now and then for stretches without gaps
			if ($urandom_range(0, 39) == 0)
				tx_gaps_on = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 39) == 0)
				rx_stalls_on = 1'($urandom_range(0, 1));
			kind = $urandom_range(0, 99);
			if (kind < 25)
				send_byte(8'($urandom_range(0, 127)));
			else if (kind < 40)
				send_pair($urandom_range(0, 1) ? PFX_LATIN1 : PFX_LATIN2,
					8'($urandom_range(128, 191)));
			else if (kind < 55)
				send_pair(PFX_CYR0, 8'($urandom_range(128, 191)));
			else if (kind < 67)
				send_pair(PFX_CYR1, 8'($urandom_range(128, 159)));
			else if (kind < 72)
				send_pair(PFX_CYR2, 8'($urandom_range(142, 147)));
			else if (kind < 80) begin
				send_byte(EURO_LEAD);
				send_pair(PFX_EURO, ($urandom_range(0, 3) == 0) ?
					8'($urandom_range(128, 255)) : EURO_TAIL);
			end else if (kind < 90)
				send_byte(8'($urandom_range(128, 255)));
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		in_byte = 8'h00;
		lead_byte = 8'h00;
		fail_count = 0;
		bytes_sent = 0;
		tx_gaps_on = 1'b0;
		rx_stalls_on = 1'b0;
		hold_glyphs = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_ascii_passthrough();
		test_latin_prefixes();
		test_euro_sign();
		test_cyrillic();
		test_unmapped_and_continuation();
		test_output_backpressure();
		test_random_text();

		byte_valid <= 1'b0;
		while (glyph_expect_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Far beyond the slowest correct run: every beat with a long gap and a long stall.
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+src
src/u8fc_pkg.sv
src/u8fc_front.sv
src/u8fc_map.sv
src/utf8_to_font_codepage_decoder_core.sv
sim/tb_top.sv
